[src/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds, consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/dtc_pkg.sv]
package dtc_pkg;

  localparam int SLOT_COUNT = 4096;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int ADDR_W   = 32;
  localparam int HANDLE_W = 48;
  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 2;

  localparam int SHIFT_LO  = 2;
  localparam int SHIFT_MID = 12;
  localparam int SHIFT_HI  = 20;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUBLISH   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_ONE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_ALL = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   address;
    logic [HANDLE_W-1:0] handle;
    logic [WORD_W-1:0]   page_frame;
    logic [WORD_W-1:0]   generation;
    logic                call_safe;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic sweep;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic clear_all;
  } sts_t;

  function automatic logic [IDX_W-1:0] slot_of(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] mix;
    logic [ADDR_W-1:0] mask;
    mix  = (a >> SHIFT_LO) ^ (a >> SHIFT_MID) ^ (a >> SHIFT_HI);
    mask = ADDR_W'(SLOT_COUNT - 1);
    mix  = mix & mask;
    return mix[IDX_W-1:0];
  endfunction

endpackage

[src/dtc_if.sv]
interface dtc_req_if;
  import dtc_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ADDR_W-1:0]   guest_address;
  logic [HANDLE_W-1:0] function_handle;
  logic                single_page;
  logic                call_safe;
  logic                call_lookup;
  logic [WORD_W-1:0]   stamp_physical_page;
  logic [WORD_W-1:0]   stamp_generation;

  modport source (
    output valid, func, guest_address, function_handle, single_page, call_safe,
           call_lookup, stamp_physical_page, stamp_generation,
    input  ready
  );

  modport sink (
    input  valid, func, guest_address, function_handle, single_page, call_safe,
           call_lookup, stamp_physical_page, stamp_generation,
    output ready
  );
endinterface

interface dtc_rsp_if;
  import dtc_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [HANDLE_W-1:0] found_handle;
  logic                changed;

  modport source (
    output valid, hit, found_handle, changed,
    input  ready
  );

  modport sink (
    input  valid, hit, found_handle, changed,
    output ready
  );
endinterface

[src/dtc_ctrl.sv]
module dtc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output dtc_pkg::cmd_t cmd,
  input  dtc_pkg::sts_t sts
);
  import dtc_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign cmd.load  = in_valid && in_ready;
  // result register must be free or draining this cycle
  assign cmd.eval  = (state == S_EVAL) && (!out_valid || out_ready);
  assign cmd.sweep = (state == S_CLEAR);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.load) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (cmd.eval) state_next = sts.clear_all ? S_CLEAR : S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.eval) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

[src/dtc_datapath.sv]
module dtc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dtc_pkg::cmd_t                 cmd,
  output dtc_pkg::sts_t                 sts,
  input  logic [dtc_pkg::FUNC_W-1:0]    func,
  input  logic [dtc_pkg::ADDR_W-1:0]    guest_address,
  input  logic [dtc_pkg::HANDLE_W-1:0]  function_handle,
  input  logic                          single_page,
  input  logic                          call_safe,
  input  logic                          call_lookup,
  input  logic [dtc_pkg::WORD_W-1:0]    stamp_physical_page,
  input  logic [dtc_pkg::WORD_W-1:0]    stamp_generation,
  output logic                          hit,
  output logic [dtc_pkg::HANDLE_W-1:0]  found_handle,
  output logic                          changed
);
  import dtc_pkg::*;

  entry_t mem [SLOT_COUNT];
  entry_t rd;

  // held transaction
  logic [FUNC_W-1:0]   func_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                single_q;
  logic                safe_q;
  logic                call_q;
  logic [WORD_W-1:0]   page_q;
  logic [WORD_W-1:0]   gen_q;
  logic [IDX_W-1:0]    idx_q;

  logic [IDX_W-1:0] sweep_cnt;

  logic   match;
  logic   pub_ok;
  logic   lookup_hit;
  logic   hit_c;
  logic   changed_c;
  logic   do_write;
  entry_t wr_entry;

  assign sts.sweep_last = (sweep_cnt == IDX_W'(SLOT_COUNT - 1));
  assign sts.clear_all  = (func_q == FUNC_CLEAR_ALL);

  assign match      = rd.valid && (rd.address == addr_q);
  assign pub_ok     = (handle_q != '0) && single_q;
  assign lookup_hit = match && (rd.handle != '0) && (!call_q || rd.call_safe) &&
                      (rd.page_frame == page_q) && (rd.generation == gen_q);

  always_comb begin
    hit_c     = 1'b0;
    changed_c = 1'b0;
    do_write  = 1'b0;
    wr_entry  = rd;
    case (func_q)
      FUNC_LOOKUP: begin
        hit_c = lookup_hit;
      end
      FUNC_PUBLISH: begin
        changed_c           = pub_ok;
        do_write            = pub_ok;
        wr_entry.valid      = 1'b1;
        wr_entry.address    = addr_q;
        wr_entry.handle     = handle_q;
        wr_entry.page_frame = page_q;
        wr_entry.generation = gen_q;
        wr_entry.call_safe  = safe_q;
      end
      FUNC_CLEAR_ONE: begin
        changed_c      = match;
        do_write       = match;
        wr_entry.valid = 1'b0;
      end
      default: begin
        changed_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd       <= mem[slot_of(guest_address)];
      func_q   <= func;
      addr_q   <= guest_address;
      handle_q <= function_handle;
      single_q <= single_page;
      safe_q   <= call_safe;
      call_q   <= call_lookup;
      page_q   <= stamp_physical_page;
      gen_q    <= stamp_generation;
      idx_q    <= slot_of(guest_address);
    end
    // sweep zeroes the whole slot; only its valid bit matters, the rest is don't care
    if (cmd.sweep) begin
      mem[sweep_cnt] <= '0;
    end else if (cmd.eval && do_write) begin
      mem[idx_q] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sts.sweep_last ? '0 : sweep_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      hit          <= hit_c;
      found_handle <= hit_c ? rd.handle : '0;
      changed      <= changed_c;
    end
  end

endmodule

[src/direct_mapped_translation_cache_top.sv]
// Direct-mapped translation cache mapping guest code addresses to translated
// function handles, one transaction at a time. The accepting edge reads its
// slot from the single-port slot memory and the evaluation state then does
// the compare and write-back and registers the result, so a new request is
// taken only once the last one has been evaluated. The next request is taken
// while a result still waits on the response channel; its compare then stalls
// until the result register drains. After reset, and after every clear-all, a
// clearing pass walks all SLOT_COUNT slots (4096 as built) of the slot memory
// one slot a cycle with the request channel held not ready.
`include "assert_macros.svh"

module direct_mapped_translation_cache_top (
  input logic   clk,
  input logic   rst,
  dtc_req_if.sink   req,
  dtc_rsp_if.source rsp
);
  import dtc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dtc_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .func                (req.func),
    .guest_address       (req.guest_address),
    .function_handle     (req.function_handle),
    .single_page         (req.single_page),
    .call_safe           (req.call_safe),
    .call_lookup         (req.call_lookup),
    .stamp_physical_page (req.stamp_physical_page),
    .stamp_generation    (req.stamp_generation),
    .hit                 (rsp.hit),
    .found_handle        (rsp.found_handle),
    .changed             (rsp.changed)
  );

  `ASSERT_SAME(a_hit_not_changed, clk, rst, rsp.valid && rsp.hit, !rsp.changed)
  `ASSERT_SAME(a_miss_zero_handle, clk, rst, rsp.valid && !rsp.hit, rsp.found_handle == '0)
  `ASSERT_SAME(a_hit_nonzero_handle, clk, rst, rsp.valid && rsp.hit, rsp.found_handle != '0)
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, req.valid && req.ready, !req.ready)

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dtc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POOL_HALF   = 24;
  localparam int POOL_SIZE   = 2 * POOL_HALF;
  // flipping bits 2, 4, 12 and 22 leaves the slot index unchanged
  localparam logic [ADDR_W-1:0] SAME_SLOT_FLIP = 32'h0040_1014;

  typedef struct packed {
    logic [FUNC_W-1:0]   op;
    logic [ADDR_W-1:0]   addr;
    logic [HANDLE_W-1:0] handle;
    logic                one_page;
    logic                call_ok;
    logic                call_kind;
    logic [WORD_W-1:0]   page;
    logic [WORD_W-1:0]   gen;
  } cache_req_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic                changed;
  } cache_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtc_req_if req_ch ();
  dtc_rsp_if rsp_ch ();

  direct_mapped_translation_cache_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the slot table
  bit                  shadow_valid   [SLOT_COUNT];
  logic [ADDR_W-1:0]   shadow_addr    [SLOT_COUNT];
  logic [HANDLE_W-1:0] shadow_handle  [SLOT_COUNT];
  logic [WORD_W-1:0]   shadow_page    [SLOT_COUNT];
  logic [WORD_W-1:0]   shadow_gen     [SLOT_COUNT];
  logic                shadow_call_ok [SLOT_COUNT];

  cache_outcome_t pending_outcomes[$];

  // addresses the random traffic keeps returning to, with the last stamp published
  logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
  logic [WORD_W-1:0] pool_page [POOL_SIZE];
  logic [WORD_W-1:0] pool_gen  [POOL_SIZE];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int cycle_count   = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("direct_mapped_translation_cache_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [IDX_W-1:0] slot_hash(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] folded;
    folded = {2'b00, a[ADDR_W-1:2]} ^ {12'h000, a[ADDR_W-1:12]} ^
             {20'h00000, a[ADDR_W-1:20]};
    return IDX_W'(folded & (SLOT_COUNT - 1));
  endfunction

  function automatic cache_outcome_t predict_outcome(input cache_req_t r);
    cache_outcome_t o;
    logic [IDX_W-1:0] s;
    o = '0;
    s = slot_hash(r.addr);
    case (r.op)
      FUNC_LOOKUP: begin
        if (shadow_valid[s] && shadow_addr[s] == r.addr && shadow_handle[s] != '0 &&
            (!r.call_kind || shadow_call_ok[s]) &&
            shadow_page[s] == r.page && shadow_gen[s] == r.gen) begin
          o.hit    = 1'b1;
          o.handle = shadow_handle[s];
        end
      end
      FUNC_PUBLISH: begin
        if (r.handle != '0 && r.one_page) begin
          shadow_valid[s]   = 1'b1;
          shadow_addr[s]    = r.addr;
          shadow_handle[s]  = r.handle;
          shadow_page[s]    = r.page;
          shadow_gen[s]     = r.gen;
          shadow_call_ok[s] = r.call_ok;
          o.changed         = 1'b1;
        end
      end
      FUNC_CLEAR_ONE: begin
        if (shadow_valid[s] && shadow_addr[s] == r.addr) begin
          shadow_valid[s] = 1'b0;
          o.changed       = 1'b1;
        end
      end
      default: begin
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        o.changed = 1'b1;
      end
    endcase
    return o;
  endfunction

  function automatic cache_req_t make_req(input logic [FUNC_W-1:0] op,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [HANDLE_W-1:0] handle,
                                          input logic one_page, input logic call_ok,
                                          input logic call_kind,
                                          input logic [WORD_W-1:0] page,
                                          input logic [WORD_W-1:0] gen);
    cache_req_t r;
    r.op        = op;
    r.addr      = addr;
    r.handle    = handle;
    r.one_page  = one_page;
    r.call_ok   = call_ok;
    r.call_kind = call_kind;
    r.page      = page;
    r.gen       = gen;
    return r;
  endfunction

  task automatic send_request(input cache_req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid               <= 1'b1;
    req_ch.func                <= r.op;
    req_ch.guest_address       <= r.addr;
    req_ch.function_handle     <= r.handle;
    req_ch.single_page         <= r.one_page;
    req_ch.call_safe           <= r.call_ok;
    req_ch.call_lookup         <= r.call_kind;
    req_ch.stamp_physical_page <= r.page;
    req_ch.stamp_generation    <= r.gen;
    do @(posedge clk); while (!req_ch.ready);
    pending_outcomes.insert(pending_outcomes.size(), predict_outcome(r));
  endtask

  always @(posedge clk) begin
    cache_outcome_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("response transaction with nothing outstanding");
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_ch.hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, rsp_ch.hit);
          fail_count++;
        end
        if (rsp_ch.found_handle !== want.handle) begin
          $error("found_handle: expected %h, got %h", want.handle, rsp_ch.found_handle);
          fail_count++;
        end
        if (rsp_ch.changed !== want.changed) begin
          $error("changed: expected %0b, got %0b", want.changed, rsp_ch.changed);
          fail_count++;
        end
      end
    end
  end

  task automatic test_publish_and_lookup();
    send_request(make_req(FUNC_LOOKUP, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0));
    send_request(make_req(FUNC_PUBLISH, '1, '1, 1'b1, 1'b1, 1'b0, '1, '1));
    send_request(make_req(FUNC_LOOKUP, '1, '0, 1'b0, 1'b0, 1'b1, '1, '1));
    // rejected publishes: null handle, then a source over more than one page
    send_request(make_req(FUNC_PUBLISH, 32'h1234_5678, '0, 1'b1, 1'b1, 1'b0, 5, 6));
    send_request(make_req(FUNC_PUBLISH, 32'h1234_5678, 48'h1, 1'b0, 1'b1, 1'b0, 5, 6));
    send_request(make_req(FUNC_LOOKUP, 32'h1234_5678, '0, 1'b1, 1'b1, 1'b0, 5, 6));
    send_request(make_req(FUNC_PUBLISH, '0, 48'h1, 1'b1, 1'b0, 1'b1, '0, '0));
    // not call-safe, so only a plain lookup may hit
    send_request(make_req(FUNC_LOOKUP, '0, '1, 1'b1, 1'b1, 1'b1, '0, '0));
    send_request(make_req(FUNC_LOOKUP, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0));
    send_request(make_req(FUNC_LOOKUP, '0, '0, 1'b0, 1'b0, 1'b0, 1, '0));
    send_request(make_req(FUNC_LOOKUP, '0, '0, 1'b0, 1'b0, 1'b0, '0, 32'h8000_0000));
  endtask

  task automatic test_slot_collision();
    send_request(make_req(FUNC_PUBLISH, SAME_SLOT_FLIP, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b1,
                          1'b0, 32'h5555_5555, 32'hAAAA_AAAA));
    send_request(make_req(FUNC_LOOKUP, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0));
    send_request(make_req(FUNC_LOOKUP, SAME_SLOT_FLIP, 48'h5555_5555_5555, 1'b0, 1'b0,
                          1'b1, 32'h5555_5555, 32'hAAAA_AAAA));
    send_request(make_req(FUNC_CLEAR_ONE, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0));
    send_request(make_req(FUNC_CLEAR_ONE, SAME_SLOT_FLIP, '0, 1'b0, 1'b0, 1'b0, '0, '0));
    send_request(make_req(FUNC_CLEAR_ONE, SAME_SLOT_FLIP, '0, 1'b0, 1'b0, 1'b0, '0, '0));
    send_request(make_req(FUNC_LOOKUP, SAME_SLOT_FLIP, '0, 1'b0, 1'b0, 1'b0,
                          32'h5555_5555, 32'hAAAA_AAAA));
  endtask

  task automatic test_clear_all();
    send_request(make_req(FUNC_CLEAR_ALL, '1, '1, 1'b1, 1'b1, 1'b1, '1, '1));
    send_request(make_req(FUNC_LOOKUP, '1, '0, 1'b0, 1'b0, 1'b1, '1, '1));
    // clear-all on an empty table still reports a change
    send_request(make_req(FUNC_CLEAR_ALL, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0));
  endtask

  function automatic cache_req_t random_request();
    cache_req_t r;
    int pick;
    int k;
    pick        = $urandom_range(99);
    k           = $urandom_range(POOL_SIZE - 1);
    r.op        = FUNC_LOOKUP;
    r.addr      = $urandom;
    r.handle    = HANDLE_W'({$urandom, $urandom});
    r.one_page  = 1'($urandom_range(1));
    r.call_ok   = 1'($urandom_range(1));
    r.call_kind = 1'($urandom_range(1));
    r.page      = $urandom;
    r.gen       = $urandom;
    if (pick < 2) begin
      r.op = FUNC_CLEAR_ALL;
    end else if (pick < 32) begin
      r.op       = FUNC_PUBLISH;
      r.addr     = pool_addr[k];
      r.one_page = ($urandom_range(9) != 0);
      if ($urandom_range(19) == 0) r.handle = '0;
      if (r.handle != '0 && r.one_page) begin
        pool_page[k] = r.page;
        pool_gen[k]  = r.gen;
      end
    end else if (pick < 42) begin
      r.op = FUNC_CLEAR_ONE;
      if ($urandom_range(4) != 0) r.addr = pool_addr[k];
    end else if ($urandom_range(6) != 0) begin
      r.addr = pool_addr[k];
      r.page = pool_page[k];
      r.gen  = pool_gen[k];
      // a stale page or generation stamp now and then
      if ($urandom_range(4) == 0) begin
        if ($urandom_range(1) != 0) r.page[$urandom_range(WORD_W - 1)] ^= 1'b1;
        else r.gen[$urandom_range(WORD_W - 1)] ^= 1'b1;
      end
    end
    return r;
  endfunction

  task automatic test_random_traffic(input int count);
    repeat (count) send_request(random_request());
  endtask

  initial begin
    req_ch.valid               <= 1'b0;
    req_ch.func                <= FUNC_LOOKUP;
    req_ch.guest_address       <= '0;
    req_ch.function_handle     <= '0;
    req_ch.single_page         <= 1'b0;
    req_ch.call_safe           <= 1'b0;
    req_ch.call_lookup         <= 1'b0;
    req_ch.stamp_physical_page <= '0;
    req_ch.stamp_generation    <= '0;
    for (int i = 0; i < POOL_HALF; i++) begin
      pool_addr[i]             = $urandom;
      pool_addr[i + POOL_HALF] = pool_addr[i] ^ SAME_SLOT_FLIP;
    end
    foreach (pool_page[i]) begin
      pool_page[i] = $urandom;
      pool_gen[i]  = $urandom;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 37;
    recv_idle_pct = 76;
    test_publish_and_lookup();
    test_slot_collision();
    test_clear_all();
    test_random_traffic(460);

    send_idle_pct = 76;
    recv_idle_pct = 37;
    test_random_traffic(460);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(460);

    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("direct_mapped_translation_cache_top: match");
    end else begin
      $display("direct_mapped_translation_cache_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/dtc_pkg.sv
src/dtc_if.sv
src/dtc_ctrl.sv
src/dtc_datapath.sv
src/direct_mapped_translation_cache_top.sv
dv/tb.sv
